// ----- hw/rtl/sensor_reply_frame_checker_assert.svh -----
// Assertion macros for the reply frame checker.
// Building with ASSERT_OFF defined turns every check into nothing.
`ifndef SENSOR_REPLY_FRAME_CHECKER_ASSERT_SVH
`define SENSOR_REPLY_FRAME_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Check prop at every rising edge of clk outside reset.
`define SRFC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("srfc assertion failed");

// Check prop at every rising edge of clk, reset included.
`define SRFC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("srfc assertion failed");

`else

`define SRFC_ASSERT(label, prop)
`define SRFC_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ----- hw/rtl/srfc_pkg.sv -----
package srfc_pkg;

    // Largest body length (data and the two checksum bytes) accepted
    localparam int MAX_BODY = 256;

    // Counter width for data positions; never below one full index byte
    localparam int CNT_W = ($clog2(MAX_BODY - 1) > 8) ? $clog2(MAX_BODY - 1) : 8;

    localparam logic [7:0] START_MARK_1 = 8'hEF;
    localparam logic [7:0] START_MARK_2 = 8'h01;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0] REPLY_ID_RESET = 8'h07;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_MARK2,
        PH_ADDR0,
        PH_ADDR1,
        PH_ADDR2,
        PH_ADDR3,
        PH_PID,
        PH_LENH,
        PH_LENL,
        PH_DATA,
        PH_SUMH,
        PH_SUML
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_START    = 3'd1,
        ERR_ADDRESS  = 3'd2,
        ERR_PID      = 3'd3,
        ERR_LENGTH   = 3'd4,
        ERR_CHECKSUM = 3'd5,
        ERR_TIMEOUT  = 3'd6
    } err_t;

    typedef enum logic {
        REG_MODULE_ADDRESS = 1'b0,
        REG_REPLY_ID       = 1'b1
    } cfg_reg_t;

    localparam logic MODE_BYTE = 1'b0;

endpackage

// ----- hw/rtl/sensor_reply_frame_checker.sv -----
// Reply frame checker: takes one received byte (or a timeout event) per transfer and
// checks the start mark EF 01, the four address bytes, the packet identifier, the
// 16-bit body length and the 16-bit checksum, passing each body data byte on with its
// index and closing every frame with one accept or reject result. An item is taken
// into an input register, decoded against the frame phase and written to a result
// register; a result waiting on out_stall holds the item in the input register. A new
// item is accepted every cycle while the output side takes results. The input register
// lets one further item in while a result waits on out_stall. The address and
// identifier registers are written through the cfg channel, which is always ready.
`include "sensor_reply_frame_checker_assert.svh"

module sensor_reply_frame_checker
    import srfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [7:0]  rx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  byte_index,
    output logic [2:0]  error_code,
    output logic        frame_end,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    // configuration
    logic [31:0]      module_address_reg;
    logic [7:0]       reply_id_reg;

    // input register
    logic             in_valid_reg;
    logic             mode_reg;
    logic [7:0]       byte_reg;

    // frame state
    phase_t           phase_reg;
    phase_t           phase_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] data_len_reg;
    logic [CNT_W-1:0] data_len_next;
    logic [7:0]       len_hi_reg;
    logic [7:0]       len_hi_next;
    logic [15:0]      sum_reg;
    logic [15:0]      sum_next;
    logic [7:0]       sum_hi_reg;
    logic [7:0]       sum_hi_next;

    // result register
    logic             out_valid_reg;
    logic             out_valid_next;
    kind_t            kind_reg;
    logic [7:0]       data_byte_reg;
    logic [7:0]       byte_index_reg;
    err_t             error_code_reg;

    logic             out_free;
    logic             proc;
    logic             in_take;

    logic             res_valid;
    kind_t            res_kind;
    err_t             res_err;

    logic [7:0]       addr_want;
    logic [15:0]      len_full;
    logic [15:0]      len_minus2;
    logic             len_bad;
    logic [15:0]      sum_add;
    logic [CNT_W-1:0] count_inc;
    logic [15:0]      sum_got;

    assign cfg_ready = 1'b1;

    assign out_free = !out_valid_reg || !out_stall;
    assign proc     = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign len_full   = {len_hi_reg, byte_reg};
    assign len_minus2 = len_full - 16'd2;
    assign len_bad    = (len_full < 16'd2) || (len_full > 16'(MAX_BODY));
    assign sum_add    = sum_reg + {8'd0, byte_reg};
    assign count_inc  = count_reg + CNT_W'(1);
    assign sum_got    = {sum_hi_reg, byte_reg};

    always_comb
    begin
        unique case (phase_reg)
            PH_ADDR0: addr_want = module_address_reg[31:24];
            PH_ADDR1: addr_want = module_address_reg[23:16];
            PH_ADDR2: addr_want = module_address_reg[15:8];
            default:  addr_want = module_address_reg[7:0];
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (mode_reg != MODE_BYTE)
        begin
            phase_next = PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                    phase_next = (byte_reg == START_MARK_1) ? PH_MARK2 : PH_HUNT;
                PH_MARK2:
                    phase_next = (byte_reg == START_MARK_2) ? PH_ADDR0 : PH_HUNT;
                PH_ADDR0:
                    phase_next = (byte_reg == addr_want) ? PH_ADDR1 : PH_HUNT;
                PH_ADDR1:
                    phase_next = (byte_reg == addr_want) ? PH_ADDR2 : PH_HUNT;
                PH_ADDR2:
                    phase_next = (byte_reg == addr_want) ? PH_ADDR3 : PH_HUNT;
                PH_ADDR3:
                    phase_next = (byte_reg == addr_want) ? PH_PID : PH_HUNT;
                PH_PID:
                    phase_next = (byte_reg == reply_id_reg) ? PH_LENH : PH_HUNT;
                PH_LENH:
                    phase_next = PH_LENL;
                PH_LENL:
                    if (len_bad)
                        phase_next = PH_HUNT;
                    else if (len_full == 16'd2)
                        phase_next = PH_SUMH;
                    else
                        phase_next = PH_DATA;
                PH_DATA:
                    phase_next = (count_inc == data_len_reg) ? PH_SUMH : PH_DATA;
                PH_SUMH:
                    phase_next = PH_SUML;
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    // result and datapath
    always_comb
    begin
        res_valid     = 1'b0;
        res_kind      = KIND_DATA;
        res_err       = ERR_NONE;
        count_next    = count_reg;
        data_len_next = data_len_reg;
        len_hi_next   = len_hi_reg;
        sum_next      = sum_reg;
        sum_hi_next   = sum_hi_reg;
        if (mode_reg != MODE_BYTE)
        begin
            // abort a partial frame; nothing to report while hunting
            if (phase_reg != PH_HUNT)
            begin
                res_valid = 1'b1;
                res_kind  = KIND_REJECT;
                res_err   = ERR_TIMEOUT;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                end
                PH_MARK2:
                    if (byte_reg != START_MARK_2)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_err   = ERR_START;
                    end
                PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3:
                    if (byte_reg != addr_want)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_err   = ERR_ADDRESS;
                    end
                PH_PID:
                begin
                    sum_next = {8'd0, byte_reg};
                    if (byte_reg != reply_id_reg)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_err   = ERR_PID;
                    end
                end
                PH_LENH:
                begin
                    len_hi_next = byte_reg;
                    sum_next    = sum_add;
                end
                PH_LENL:
                begin
                    sum_next      = sum_add;
                    count_next    = '0;
                    data_len_next = len_minus2[CNT_W-1:0];
                    if (len_bad)
                    begin
                        res_valid = 1'b1;
                        res_kind  = KIND_REJECT;
                        res_err   = ERR_LENGTH;
                    end
                end
                PH_DATA:
                begin
                    sum_next   = sum_add;
                    count_next = count_inc;
                    res_valid  = 1'b1;
                    res_kind   = KIND_DATA;
                end
                PH_SUMH:
                    sum_hi_next = byte_reg;
                PH_SUML:
                begin
                    res_valid = 1'b1;
                    if (sum_got == sum_reg)
                    begin
                        res_kind = KIND_ACCEPT;
                    end
                    else
                    begin
                        res_kind = KIND_REJECT;
                        res_err  = ERR_CHECKSUM;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (proc)
            out_valid_next = res_valid;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            module_address_reg <= ADDR_RESET;
            reply_id_reg       <= REPLY_ID_RESET;
            in_valid_reg       <= 1'b0;
            phase_reg          <= PH_HUNT;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_MODULE_ADDRESS: module_address_reg <= cfg_data;
                    REG_REPLY_ID:       reply_id_reg       <= cfg_data[7:0];
                endcase
            end
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (proc)
                in_valid_reg <= 1'b0;
            if (proc)
                phase_reg <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            byte_reg <= rx_byte;
        end
        if (proc)
        begin
            count_reg    <= count_next;
            data_len_reg <= data_len_next;
            len_hi_reg   <= len_hi_next;
            sum_reg      <= sum_next;
            sum_hi_reg   <= sum_hi_next;
        end
        // hold the result until it is taken
        if (proc && res_valid)
        begin
            kind_reg       <= res_kind;
            error_code_reg <= res_err;
            if (res_kind == KIND_DATA)
            begin
                data_byte_reg  <= byte_reg;
                byte_index_reg <= count_reg[7:0];
            end
            else
            begin
                data_byte_reg  <= 8'd0;
                byte_index_reg <= 8'd0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign data_byte  = data_byte_reg;
    assign byte_index = byte_index_reg;
    assign error_code = error_code_reg;
    assign frame_end  = (kind_reg != KIND_DATA);

    `SRFC_ASSERT(a_reject_has_code,
        out_valid_reg && kind_reg == KIND_REJECT |-> error_code_reg != ERR_NONE)
    `SRFC_ASSERT(a_data_only_in_body,
        proc && res_valid && res_kind == KIND_DATA |-> phase_reg == PH_DATA)
    `SRFC_ASSERT(a_end_returns_to_hunt,
        proc && res_valid && res_kind != KIND_DATA |=> phase_reg == PH_HUNT)
    `SRFC_ASSERT_ALWAYS(a_no_stall_when_empty,
        !in_valid_reg |-> !in_stall)

endmodule

// ----- verif/sensor_reply_frame_checker_tb.sv -----
`timescale 1ns / 1ps

module sensor_reply_frame_checker_tb;
    import srfc_pkg::*;

    localparam int   IDLE_LIMIT    = 2000;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   RANDOM_BYTES  = 600;
    localparam logic MODE_TIMEOUT  = ~MODE_BYTE;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic [7:0] index;
        err_t       err;
        logic       fend;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        mode = MODE_BYTE;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [2:0]  error_code;
    logic        frame_end;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index = REG_MODULE_ADDRESS;
    logic [31:0] cfg_data = 32'h0;

    // frame tracker state and its copy of the registers
    phase_t      ph = PH_HUNT;
    int          data_count = 0;
    logic [15:0] frame_len = 16'h0;
    logic [15:0] run_sum = 16'h0;
    logic [7:0]  sum_hi = 8'h0;
    logic [31:0] exp_addr = ADDR_RESET;
    logic [7:0]  exp_pid = REPLY_ID_RESET;

    reply_t      expected_replies[$];
    logic [7:0]  frame_bytes[$];

    bit          quiet = 1'b0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          items_sent = 0;
    int          stall_left = 0;

    sensor_reply_frame_checker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .error_code (error_code),
        .frame_end  (frame_end),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void push_reply(kind_t k, logic [7:0] d, logic [7:0] i, err_t e,
                                       logic f);
        reply_t r;
        r.kind = k;
        r.data = d;
        r.index = i;
        r.err = e;
        r.fend = f;
        expected_replies.push_back(r);
    endfunction

    function automatic void restart_frame();
        ph = PH_HUNT;
        data_count = 0;
        frame_len = 16'h0;
        run_sum = 16'h0;
        sum_hi = 8'h0;
    endfunction

    function automatic void reject_frame(err_t e);
        restart_frame();
        push_reply(KIND_REJECT, 8'h00, 8'h00, e, 1'b1);
    endfunction

    function automatic void track_frame_byte(logic m, logic [7:0] b);
        int          shift;
        logic [7:0]  want;
        logic [15:0] got;
        if (m != MODE_BYTE) begin
            if (ph != PH_HUNT)
                reject_frame(ERR_TIMEOUT);
            return;
        end
        case (ph)
            PH_HUNT:
                if (b == START_MARK_1)
                    ph = PH_MARK2;
            PH_MARK2:
                if (b != START_MARK_2)
                    reject_frame(ERR_START);
                else
                    ph = PH_ADDR0;
            PH_ADDR0, PH_ADDR1, PH_ADDR2, PH_ADDR3:
            begin
                shift = 8 * (int'(PH_ADDR3) - int'(ph));
                want = 8'(exp_addr >> shift);
                if (b != want)
                    reject_frame(ERR_ADDRESS);
                else
                    ph = phase_t'(ph + 1);
            end
            PH_PID:
                if (b != exp_pid)
                    reject_frame(ERR_PID);
                else
                begin
                    run_sum = {8'h00, b};
                    ph = PH_LENH;
                end
            PH_LENH:
            begin
                frame_len = {b, 8'h00};
                run_sum = run_sum + b;
                ph = PH_LENL;
            end
            PH_LENL:
            begin
                frame_len[7:0] = b;
                run_sum = run_sum + b;
                if (frame_len < 2 || frame_len > MAX_BODY)
                    reject_frame(ERR_LENGTH);
                else
                begin
                    data_count = 0;
                    ph = (frame_len == 2) ? PH_SUMH : PH_DATA;
                end
            end
            PH_DATA:
            begin
                run_sum = run_sum + b;
                push_reply(KIND_DATA, b, 8'(data_count), ERR_NONE, 1'b0);
                data_count++;
                if (data_count >= int'(frame_len) - 2)
                    ph = PH_SUMH;
            end
            PH_SUMH:
            begin
                sum_hi = b;
                ph = PH_SUML;
            end
            PH_SUML:
            begin
                got = {sum_hi, b};
                if (got != run_sum)
                    reject_frame(ERR_CHECKSUM);
                else
                begin
                    restart_frame();
                    push_reply(KIND_ACCEPT, 8'h00, 8'h00, ERR_NONE, 1'b1);
                end
            end
            default:
                restart_frame();
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic send_item(input logic m, input logic [7:0] b);
        int gap;
        bit taken;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        rx_byte <= b;
        taken = 1'b0;
        while (!taken)
        begin
            // decide at the falling edge; the transfer lands on the next rising edge
            @(negedge clk);
            taken = !in_stall;
            if (taken)
            begin
                track_frame_byte(m, b);
                items_sent++;
            end
            @(posedge clk);
        end
    endtask

    task automatic send_timeout();
        send_item(MODE_TIMEOUT, 8'($urandom));
    endtask

    function automatic void build_frame(logic [31:0] addr, logic [7:0] pid, int n_data,
                                        logic [15:0] len_field, bit bad_sum);
        logic [15:0] sum;
        logic [7:0]  d;
        frame_bytes.delete();
        frame_bytes.push_back(START_MARK_1);
        frame_bytes.push_back(START_MARK_2);
        for (int i = 3; i >= 0; i--)
            frame_bytes.push_back(8'(addr >> (8 * i)));
        frame_bytes.push_back(pid);
        frame_bytes.push_back(len_field[15:8]);
        frame_bytes.push_back(len_field[7:0]);
        sum = 16'(pid) + len_field[15:8] + len_field[7:0];
        for (int i = 0; i < n_data; i++)
        begin
            d = 8'($urandom);
            frame_bytes.push_back(d);
            sum = sum + d;
        end
        if (bad_sum)
            sum = sum ^ 16'(1 << $urandom_range(0, 15));
        frame_bytes.push_back(sum[15:8]);
        frame_bytes.push_back(sum[7:0]);
    endfunction

    task automatic send_prefix(input int count);
        for (int i = 0; i < count && i < frame_bytes.size(); i++)
            send_item(MODE_BYTE, frame_bytes[i]);
    endtask

    task automatic send_good_frame(input int n_data);
        build_frame(exp_addr, exp_pid, n_data, 16'(n_data + 2), 1'b0);
        send_prefix(frame_bytes.size());
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // close any open frame, then let the pipeline empty out
    task automatic settle_block();
        if (ph != PH_HUNT)
            send_timeout();
        wait_for_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        bit done;
        settle_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        done = 1'b0;
        while (!done)
        begin
            @(negedge clk);
            done = cfg_ready;
            if (done)
            begin
                if (idx == REG_MODULE_ADDRESS)
                    exp_addr = value;
                else
                    exp_pid = value[7:0];
            end
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_frames();
        // noise and a timeout while hunting give nothing
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hFF);
        send_item(MODE_BYTE, START_MARK_2);
        send_timeout();
        send_good_frame(0);
        send_good_frame(3);
        // bad second mark; the repeated EF is not a new start
        send_item(MODE_BYTE, START_MARK_1);
        send_item(MODE_BYTE, START_MARK_1);
        send_item(MODE_BYTE, START_MARK_2);
        build_frame(exp_addr ^ 32'h0001_0000, exp_pid, 0, 16'd2, 1'b0);
        send_prefix(4);
        build_frame(exp_addr, exp_pid ^ 8'h80, 0, 16'd2, 1'b0);
        send_prefix(7);
        build_frame(exp_addr, exp_pid, 0, 16'd0, 1'b0);
        send_prefix(9);
        build_frame(exp_addr, exp_pid, 0, 16'd1, 1'b0);
        send_prefix(9);
        build_frame(exp_addr, exp_pid, 0, 16'(MAX_BODY + 1), 1'b0);
        send_prefix(9);
        build_frame(exp_addr, exp_pid, 0, 16'hFFFF, 1'b0);
        send_prefix(9);
        build_frame(exp_addr, exp_pid, 4, 16'd6, 1'b1);
        send_prefix(frame_bytes.size());
        // timeouts part way through a frame
        build_frame(exp_addr, exp_pid, 5, 16'd7, 1'b0);
        send_prefix(3);
        send_timeout();
        send_prefix(11);
        send_timeout();
        send_prefix(frame_bytes.size() - 1);
        send_timeout();
        settle_block();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_MODULE_ADDRESS, 32'h0000_0000);
        write_reg(REG_REPLY_ID, 32'h0000_0000);
        send_good_frame(2);
        write_reg(REG_MODULE_ADDRESS, 32'hEF01_EF01);
        write_reg(REG_REPLY_ID, 32'h0000_00FF);
        send_good_frame(1);
        build_frame(exp_addr, 8'h7F, 0, 16'd2, 1'b0);
        send_prefix(7);
        write_reg(REG_MODULE_ADDRESS, ADDR_RESET);
        write_reg(REG_REPLY_ID, {24'h0, START_MARK_1});
        send_good_frame(4);
        settle_block();
    endtask

    task automatic test_long_bodies();
        write_reg(REG_REPLY_ID, 32'h0000_00FF);
        send_good_frame(MAX_BODY - 2);
        write_reg(REG_REPLY_ID, {24'h0, REPLY_ID_RESET});
        settle_block();
    endtask

    task automatic random_frame();
        int          n_data;
        int          flaw;
        int          cut;
        logic [15:0] len_field;
        n_data = ($urandom_range(0, 19) == 0) ? $urandom_range(0, MAX_BODY - 2)
                                              : $urandom_range(0, 14);
        flaw = ($urandom_range(0, 99) < 70) ? 0 : $urandom_range(1, 7);
        len_field = 16'(n_data + 2);
        if (flaw == 4)
            len_field = $urandom_range(0, 1) ? 16'($urandom_range(0, 1))
                                             : 16'($urandom_range(MAX_BODY + 1, 65535));
        build_frame(exp_addr, exp_pid, n_data, len_field, flaw == 5);
        case (flaw)
            1: frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
            2:
            begin
                cut = $urandom_range(2, 5);
                frame_bytes[cut] = frame_bytes[cut] ^ 8'(1 << $urandom_range(0, 7));
            end
            3: frame_bytes[6] = frame_bytes[6] ^ 8'(1 << $urandom_range(0, 7));
            7:
                repeat ($urandom_range(1, 5)) frame_bytes.push_front(8'($urandom));
            default: ;
        endcase
        cut = frame_bytes.size();
        if (flaw == 4)
            cut = 9;
        else if (flaw == 6)
            cut = $urandom_range(1, frame_bytes.size() - 1);
        send_prefix(cut);
        if (flaw == 6)
            send_timeout();
    endtask

    task automatic test_random_traffic();
        int base;
        for (int seg = 0; seg < 5; seg++)
        begin
            if (seg == 0)
            begin
                write_reg(REG_MODULE_ADDRESS, 32'h0000_0000);
                write_reg(REG_REPLY_ID, 32'h0000_0000);
            end
            else if (seg == 4)
            begin
                write_reg(REG_MODULE_ADDRESS, ADDR_RESET);
                write_reg(REG_REPLY_ID, 32'h0000_00FF);
            end
            else
            begin
                write_reg(REG_MODULE_ADDRESS, $urandom);
                write_reg(REG_REPLY_ID, $urandom_range(0, 255));
            end
            base = items_sent;
            quiet = (seg == 3);
            while (items_sent - base < RANDOM_BYTES / 5)
            begin
                random_frame();
                // past half of segment 2, hold the sender after each frame until every reply is out
                if (seg == 2 && items_sent - base > RANDOM_BYTES / 10 && ph == PH_HUNT
                    && expected_replies.size() != 0)
                    wait_for_replies();
            end
            quiet = 1'b0;
        end
        settle_block();
    endtask

    // output side stall pattern: mostly short, a few long stretches
    always @(posedge clk)
    begin
        int r;
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else if (quiet)
            out_stall <= 1'b0;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(20, 60);
            end
        end
    end

    function automatic void flag_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    always @(negedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_replies.size() == 0)
                flag_mismatch($sformatf(
                    "unexpected reply: kind %0d data %02h index %0d err %0d end %0b",
                    kind, data_byte, byte_index, error_code, frame_end));
            else
            begin
                want = expected_replies.pop_front();
                if (kind !== want.kind || data_byte !== want.data
                    || byte_index !== want.index || error_code !== want.err
                    || frame_end !== want.fend)
                    flag_mismatch($sformatf(
                        {"reply mismatch: expected kind %0d data %02h index %0d err %0d",
                         " end %0b, got kind %0d data %02h index %0d err %0d end %0b"},
                        want.kind, want.data, want.index, want.err, want.fend,
                        kind, data_byte, byte_index, error_code, frame_end));
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(negedge clk);
        $display("sensor_reply_frame_checker_tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_register_extremes();
        test_long_bodies();
        test_random_traffic();
        if (mismatches == 0 && expected_replies.size() == 0)
            $display("sensor_reply_frame_checker_tb OK");
        else
            $display("sensor_reply_frame_checker_tb NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/srfc_pkg.sv
hw/rtl/sensor_reply_frame_checker.sv
verif/sensor_reply_frame_checker_tb.sv
